### hw/rtl/trial_division_prime_test_top_defines.svh
// Assertion macros for the prime test block.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

`ifndef SYNTH
// clocked check, off while reset is asserted
`define TDPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdpt assertion failed");
// clocked check, also active during reset
`define TDPT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tdpt assertion failed");
`else
`define TDPT_ASSERT(lbl, clk, rst_n, prop)
`define TDPT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hw/rtl/tdpt_pkg.sv
package tdpt_pkg;

    localparam int CANDIDATE_WIDTH    = 32;
    localparam int DEF_NUMBER_WIDTH   = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_DIV,
        S_DECIDE,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture candidate, divisor = 3
        logic start_div;  // clear remainder, reload dividend
        logic step;       // one restoring division step
        logic next_d;     // divisor += 2
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic lt2;
        logic lt4;
        logic even;
        logic div_last;
        logic rem_zero;
        logic d_gt_q;
    } t_dp_status;

endpackage

### hw/rtl/tdpt_if.sv
interface tdpt_in_if import tdpt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CANDIDATE_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_out_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

### hw/rtl/tdpt_datapath.sv
`include "trial_division_prime_test_top_defines.svh"

module tdpt_datapath import tdpt_pkg::*; #(
    parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [CANDIDATE_WIDTH-1:0] i_candidate,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status
);

    localparam int W  = NUMBER_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_n,   n_n;
    logic [W-1:0]  r_d,   n_d;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    // restoring division: shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_comb begin
        n_n   = r_n;
        n_d   = r_d;
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_n = W'(i_candidate);
            n_d = W'(3);
        end
        if (i_cmd.next_d) begin
            n_d = r_d + W'(2);
        end
        if (i_cmd.start_div) begin
            n_rem = '0;
            n_quo = r_n;
            n_cnt = '0;
        end else if (i_cmd.step) begin
            if (!w_diff[W]) begin
                n_rem = w_diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    // quotient sits in r_quo once all steps are done
    assign o_status.lt2      = (r_n < W'(2));
    assign o_status.lt4      = (r_n < W'(4));
    assign o_status.even     = ~r_n[0];
    assign o_status.div_last = (r_cnt == CW'(W - 1));
    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.d_gt_q   = (r_d > r_quo);

    `TDPT_ASSERT(a_rem_below_divisor, i_clk, i_rst_n, i_cmd.step |-> (r_rem < r_d))
    `TDPT_ASSERT(a_divisor_odd, i_clk, i_rst_n, i_cmd.step |-> r_d[0])

endmodule

### hw/rtl/tdpt_ctrl.sv
`include "trial_division_prime_test_top_defines.svh"

module tdpt_ctrl import tdpt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output logic       o_is_prime,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_verdict, n_verdict;
    logic   r_out_valid, n_out_valid;
    logic   r_is_prime, n_is_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict  <= n_verdict;
        r_is_prime <= n_is_prime;
    end

    always_comb begin
        n_state     = r_state;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid && !i_out_ready;
        n_is_prime  = r_is_prime;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                if (i_status.lt2) begin
                    n_verdict = 1'b0;
                    n_state   = S_FINISH;
                end else if (i_status.lt4) begin
                    n_verdict = 1'b1;
                    n_state   = S_FINISH;
                end else if (i_status.even) begin
                    n_verdict = 1'b0;
                    n_state   = S_FINISH;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // divisor past n/d means no factor up to sqrt(n)
                if (i_status.d_gt_q) begin
                    n_verdict = 1'b1;
                    n_state   = S_FINISH;
                end else if (i_status.rem_zero) begin
                    n_verdict = 1'b0;
                    n_state   = S_FINISH;
                end else begin
                    o_cmd.next_d    = 1'b1;
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_is_prime  = r_verdict;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_is_prime;

    `TDPT_ASSERT(a_accept_to_classify, i_clk, i_rst_n, (o_in_ready && i_in_valid) |=> (r_state == S_CLASSIFY))
    `TDPT_ASSERT(a_finish_holds_on_stall, i_clk, i_rst_n, (r_state == S_FINISH && r_out_valid && !i_out_ready) |=> (r_state == S_FINISH))
    `TDPT_ASSERT(a_factor_is_composite, i_clk, i_rst_n, (r_state == S_DECIDE && !i_status.d_gt_q && i_status.rem_zero) |=> (r_state == S_FINISH && !r_verdict))

endmodule

### hw/rtl/trial_division_prime_test_top.sv
// Trial-division prime tester: takes one 32-bit candidate word and returns one is_prime word.
// The candidate is cut or zero-extended to NUMBER_WIDTH bits (W). Values below 2, 2 and 3,
// and even values above 2 are settled in the classify state without division. An odd
// candidate n of 5 or more is divided by 3, 5, 7 and so on in a bit-serial restoring
// divider, with a decision state after each divisor; the number of divisors tried is up
// to about sqrt(n)/2, so a 32-bit prime near 2^32 needs roughly 32768 of them. One
// candidate is worked on at a time; the next can be accepted while the previous result
// waits in the output register.
module trial_division_prime_test_top import tdpt_pkg::*; #(
    parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tdpt_in_if.sink           i_in,
    tdpt_out_if.source        o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tdpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_is_prime  (o_out.is_prime),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tdpt_datapath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_candidate (i_in.candidate),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

### tb/tdpt_prime_checker.sv
module tdpt_prime_checker import tdpt_pkg::*; #(
    parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tdpt_in_if   i_in,
    tdpt_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CANDIDATE_WIDTH-1:0] candidate;
        bit                         is_prime;
    } prime_verdict_t;

    prime_verdict_t verdicts_due[$];
    int             fails = 0;

    assign o_fail_count = fails;

    initial o_pending = 0;

    // Datapath cuts the candidate to NUMBER_WIDTH bits before testing it.
    function automatic bit trial_prime(input logic [CANDIDATE_WIDTH-1:0] word);
        logic [63:0] mask;
        logic [63:0] n;
        logic [63:0] d;
        mask = (NUMBER_WIDTH >= 64) ? '1 : ((64'd1 << NUMBER_WIDTH) - 64'd1);
        n = 64'(word) & mask;
        if (n < 64'd2) return 1'b0;
        if (n < 64'd4) return 1'b1;
        if (!n[0]) return 1'b0;
        // d <= n/d keeps the bound test free of overflow
        for (d = 64'd3; d <= n / d; d += 64'd2) begin
            if (n % d == 64'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        fails++;
    endtask

    always @(posedge i_clk) begin
        prime_verdict_t due;
        if (i_rst_n) begin
            // result side first: a word leaving now belongs to an earlier candidate
            if (i_out.valid && i_out.ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("is_prime=%b with no candidate pending",
                                              i_out.is_prime));
                end else begin
                    due = verdicts_due.pop_front();
                    if (i_out.is_prime !== due.is_prime)
                        report_mismatch($sformatf("candidate %0d: is_prime=%b, want %b",
                                                  due.candidate, i_out.is_prime,
                                                  due.is_prime));
                end
            end
            if (i_in.valid && i_in.ready) begin
                due.candidate = i_in.candidate;
                due.is_prime  = trial_prime(i_in.candidate);
                verdicts_due.push_back(due);
            end
        end
        o_pending <= verdicts_due.size();
    end

endmodule

### tb/tb_top.sv
module tb_top import tdpt_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUMBER_WIDTH = DEF_NUMBER_WIDTH;

    logic i_clk;
    logic i_rst_n;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   fail_count;
    int   verdicts_pending;

    tdpt_in_if  cand_ch ();
    tdpt_out_if verdict_ch ();

    trial_division_prime_test_top #(.NUMBER_WIDTH(NUMBER_WIDTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cand_ch),
        .o_out   (verdict_ch)
    );

    tdpt_prime_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_prime_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (cand_ch),
        .i_out        (verdict_ch),
        .o_fail_count (fail_count),
        .o_pending    (verdicts_pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(negedge i_clk) begin
        verdict_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // the biggest 24-bit prime is the slowest directed candidate; random ones stay far below it
    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_candidate(input logic [CANDIDATE_WIDTH-1:0] word);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < sender_idle_pct) begin
                cand_ch.valid     <= 1'b0;
                cand_ch.candidate <= $urandom;
            end else begin
                cand_ch.valid     <= 1'b1;
                cand_ch.candidate <= word;
                break;
            end
        end
        do @(posedge i_clk); while (!(cand_ch.valid && cand_ch.ready));
    endtask

    task automatic hold_until_drained();
        do begin
            @(negedge i_clk);
            cand_ch.valid <= 1'b0;
        end while (verdicts_pending != 0);
    endtask

    initial begin
        logic [CANDIDATE_WIDTH-1:0] directed[$];
        int                         send_idle[3];
        int                         recv_idle[3];
        int                         phase_words[3];
        int                         pick;
        int                         p;
        logic [CANDIDATE_WIDTH-1:0] m;
        logic [CANDIDATE_WIDTH-1:0] word;

        // below 2, 2 and 3, small even/odd, prime squares, biggest 16/24-bit primes,
        // all-ones and alternating patterns (fast exits at full width)
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
                     32'd9, 32'd15, 32'd25, 32'd49, 32'd97, 32'd121, 32'd63001,
                     32'd65521, 32'd16777213, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                     32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
        send_idle   = '{24, 69, 0};
        recv_idle   = '{69, 24, 0};
        phase_words = '{34, 33, 33};

        i_rst_n              = 1'b0;
        cand_ch.valid        = 1'b0;
        cand_ch.candidate    = '0;
        verdict_ch.ready     = 1'b0;
        sender_idle_pct      = send_idle[0];
        receiver_idle_pct    = recv_idle[0];

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_candidate(directed[i]);

        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct   = send_idle[ph];
            receiver_idle_pct = recv_idle[ph];
            for (int i = 0; i < phase_words[ph]; i++) begin
                if (ph == 1 && i == 15) hold_until_drained();
                // sizes kept small or easy to factor: a full-width prime would need about 32768 divisors
                pick = $urandom_range(99);
                if (pick < 40) begin
                    word = $urandom_range(4095);
                end else if (pick < 60) begin
                    word = $urandom_range(65535);
                end else if (pick < 75) begin
                    word = $urandom & 32'hFFFF_FFFE;
                end else if (pick < 95) begin
                    // odd word up to full width with a small odd factor
                    p    = 2 * $urandom_range(1, 20) + 1;
                    m    = $urandom_range(32'hFFFF_FFFF / p - 1) | 32'd1;
                    word = m * p;
                end else begin
                    word = $urandom_range(32'h000F_FFFF);
                end
                send_candidate(word);
            end
        end

        hold_until_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
